// File: hdl/lge_pkg.sv
// shared types and constants of the life generation engine
package lge_pkg;

    localparam int OP_W      = 2;
    localparam int COORD_W   = 6;
    localparam int DIM_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int COUNT_W   = 4;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

    localparam logic RES_READ = 1'b0;
    localparam logic RES_STEP = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_COLS = 2'd1;

    localparam logic [DIM_W-1:0] BOARD_DIM_RESET = 7'd64;

    localparam logic [COUNT_W-1:0] BIRTH_COUNT   = 4'd3;
    localparam logic [COUNT_W-1:0] SURVIVE_COUNT = 4'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_STEP,
        ST_DONE
    } state_t;

endpackage

// File: hdl/lge_bank_ram.sv
// one bank of board rows, one write and one registered read per cycle
module lge_bank_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/lge_row_rule.sv
// next generation of one row from the rows above, at and below it
module lge_row_rule #(
    parameter int WIDTH = 64
) (
    input  logic [WIDTH-1:0] above,
    input  logic [WIDTH-1:0] cur,
    input  logic [WIDTH-1:0] below,
    input  logic [WIDTH-1:0] col_mask,
    output logic [WIDTH-1:0] next_row
);

    logic [WIDTH+1:0]              a_ext;
    logic [WIDTH+1:0]              c_ext;
    logic [WIDTH+1:0]              b_ext;
    logic [lge_pkg::COUNT_W-1:0]   cnt;

    always_comb begin
        a_ext = {1'b0, above, 1'b0};
        c_ext = {1'b0, cur, 1'b0};
        b_ext = {1'b0, below, 1'b0};
        cnt   = '0;
        for (int c = 0; c < WIDTH; c++) begin
            cnt = lge_pkg::COUNT_W'(a_ext[c]) + lge_pkg::COUNT_W'(a_ext[c+1])
                + lge_pkg::COUNT_W'(a_ext[c+2]) + lge_pkg::COUNT_W'(c_ext[c])
                + lge_pkg::COUNT_W'(c_ext[c+2]) + lge_pkg::COUNT_W'(b_ext[c])
                + lge_pkg::COUNT_W'(b_ext[c+1]) + lge_pkg::COUNT_W'(b_ext[c+2]);
            next_row[c] = col_mask[c] & ((cnt == lge_pkg::BIRTH_COUNT)
                        | (cur[c] & (cnt == lge_pkg::SURVIVE_COUNT)));
        end
    end

endmodule

// File: hdl/life_generation_engine.sv
// top level of the life generation engine: control, banks and result register
//
// channel   direction  ports
// s_*       in         s_valid s_ready s_operation s_cell_row s_cell_col s_cell_in
// m_*       out        m_valid m_ready m_result_kind m_cell_out
// cfg_*     in         cfg_valid cfg_ready cfg_index cfg_data
//
// cell read and cell write: one bank read, then result or write back
// a step: accept, then a row pass through the banks, then the result is posted
// W = min(MAX_ROWS, 127); a step reads bank rows 0 to W - 1 and writes rows 0 to W - 1
// after reset a clearing pass zeroes rows 0 to W - 1 of both banks, no request taken
// a result waits in the output register; the next request is taken meanwhile,
// and only a request that has a result ready stalls until the register frees
module life_generation_engine #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [lge_pkg::OP_W-1:0]        s_operation,
    input  logic [lge_pkg::COORD_W-1:0]     s_cell_row,
    input  logic [lge_pkg::COORD_W-1:0]     s_cell_col,
    input  logic                            s_cell_in,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_result_kind,
    output logic                            m_cell_out,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lge_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lge_pkg::DIM_W-1:0]       cfg_data
);

    localparam int WALK_ROWS = (MAX_ROWS < 127) ? MAX_ROWS : 127;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int CNT_W     = $clog2(WALK_ROWS + 2);

    lge_pkg::state_t            state_reg, state_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       active_bank_reg, active_bank_next;
    logic [lge_pkg::DIM_W-1:0]  board_rows_reg, board_rows_next;
    logic [lge_pkg::DIM_W-1:0]  board_cols_reg, board_cols_next;
    logic [ROW_W-1:0]           op_row_reg, op_row_next;
    logic [COL_W-1:0]           op_col_reg, op_col_next;
    logic                       op_val_reg, op_val_next;
    logic                       op_inside_reg, op_inside_next;
    logic [MAX_COLS-1:0]        above_reg, above_next;
    logic [MAX_COLS-1:0]        cur_reg, cur_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_kind_reg, out_kind_next;
    logic                       out_cell_reg, out_cell_next;

    logic                       rd_en;
    logic [ROW_W-1:0]           rd_addr;
    logic [MAX_COLS-1:0]        rd_data0;
    logic [MAX_COLS-1:0]        rd_data1;
    logic                       wr_en0;
    logic                       wr_en1;
    logic [ROW_W-1:0]           wr_addr;
    logic [MAX_COLS-1:0]        wr_data;

    logic [MAX_COLS-1:0]        col_mask;
    logic [MAX_COLS-1:0]        src_row;
    logic [MAX_COLS-1:0]        mod_row;
    logic [MAX_COLS-1:0]        incoming;
    logic [MAX_COLS-1:0]        next_row;
    logic [MAX_COLS-1:0]        step_wr_data;
    logic                       in_row_ok;
    logic                       out_row_ok;
    logic                       s_inside;
    logic                       out_free;

    lge_bank_ram #(
        .DEPTH  (MAX_ROWS),
        .WIDTH  (MAX_COLS),
        .ADDR_W (ROW_W)
    ) u_bank0 (
        .aclk    (aclk),
        .wr_en   (wr_en0),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data0)
    );

    lge_bank_ram #(
        .DEPTH  (MAX_ROWS),
        .WIDTH  (MAX_COLS),
        .ADDR_W (ROW_W)
    ) u_bank1 (
        .aclk    (aclk),
        .wr_en   (wr_en1),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data1)
    );

    lge_row_rule #(
        .WIDTH (MAX_COLS)
    ) u_rule (
        .above    (above_reg),
        .cur      (cur_reg),
        .below    (incoming),
        .col_mask (col_mask),
        .next_row (next_row)
    );

    always_comb begin
        for (int c = 0; c < MAX_COLS; c++) begin
            col_mask[c] = (c < int'(board_cols_reg));
        end
    end

    assign src_row  = active_bank_reg ? rd_data1 : rd_data0;
    assign s_inside = (int'(s_cell_row) < int'(board_rows_reg)) && (int'(s_cell_row) < MAX_ROWS)
                   && (int'(s_cell_col) < int'(board_cols_reg)) && (int'(s_cell_col) < MAX_COLS);

    // row arriving from the bank during a step is row cnt - 1
    assign in_row_ok    = (cnt_reg != '0) && (int'(cnt_reg) <= WALK_ROWS)
                       && ((int'(cnt_reg) - 1) < int'(board_rows_reg));
    assign incoming     = in_row_ok ? (src_row & col_mask) : '0;
    assign out_row_ok   = (int'(cnt_reg) - 2) < int'(board_rows_reg);
    assign step_wr_data = out_row_ok ? next_row : '0;

    always_comb begin
        mod_row             = src_row;
        mod_row[op_col_reg] = op_val_reg;
    end

    assign out_free  = !out_valid_reg || m_ready;
    assign cfg_ready = 1'b1;

    assign m_valid       = out_valid_reg;
    assign m_result_kind = out_kind_reg;
    assign m_cell_out    = out_cell_reg;

    always_comb begin
        board_rows_next = board_rows_reg;
        board_cols_next = board_cols_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                lge_pkg::CFG_BOARD_ROWS: board_rows_next = cfg_data;
                lge_pkg::CFG_BOARD_COLS: board_cols_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        active_bank_next = active_bank_reg;
        op_row_next      = op_row_reg;
        op_col_next      = op_col_reg;
        op_val_next      = op_val_reg;
        op_inside_next   = op_inside_reg;
        above_next       = above_reg;
        cur_next         = cur_reg;
        out_valid_next   = out_valid_reg && !m_ready;
        out_kind_next    = out_kind_reg;
        out_cell_next    = out_cell_reg;
        s_ready          = 1'b0;
        rd_en            = 1'b0;
        rd_addr          = '0;
        wr_en0           = 1'b0;
        wr_en1           = 1'b0;
        wr_addr          = '0;
        wr_data          = '0;

        unique case (state_reg)
            lge_pkg::ST_CLEAR: begin
                wr_en0  = 1'b1;
                wr_en1  = 1'b1;
                wr_addr = ROW_W'(cnt_reg);
                if (int'(cnt_reg) == WALK_ROWS - 1) begin
                    cnt_next   = '0;
                    state_next = lge_pkg::ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            lge_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                rd_addr = ROW_W'(s_cell_row);
                if (s_valid) begin
                    op_row_next    = ROW_W'(s_cell_row);
                    op_col_next    = COL_W'(s_cell_col);
                    op_val_next    = s_cell_in;
                    op_inside_next = s_inside;
                    unique case (s_operation)
                        lge_pkg::OP_WRITE: begin
                            rd_en      = 1'b1;
                            state_next = lge_pkg::ST_WRITE;
                        end
                        lge_pkg::OP_READ: begin
                            rd_en      = 1'b1;
                            state_next = lge_pkg::ST_READ;
                        end
                        lge_pkg::OP_STEP: begin
                            cnt_next   = '0;
                            above_next = '0;
                            cur_next   = '0;
                            state_next = lge_pkg::ST_STEP;
                        end
                        default: ;
                    endcase
                end
            end
            lge_pkg::ST_WRITE: begin
                wr_addr    = op_row_reg;
                wr_data    = mod_row;
                wr_en0     = op_inside_reg && !active_bank_reg;
                wr_en1     = op_inside_reg && active_bank_reg;
                state_next = lge_pkg::ST_IDLE;
            end
            lge_pkg::ST_READ: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = lge_pkg::RES_READ;
                    out_cell_next  = op_inside_reg & src_row[op_col_reg];
                    state_next     = lge_pkg::ST_IDLE;
                end
            end
            lge_pkg::ST_STEP: begin
                rd_en   = int'(cnt_reg) < WALK_ROWS;
                rd_addr = ROW_W'(cnt_reg);
                if (cnt_reg != '0) begin
                    above_next = cur_reg;
                    cur_next   = incoming;
                end
                if (int'(cnt_reg) >= 2) begin
                    wr_addr = ROW_W'(cnt_reg - CNT_W'(2));
                    wr_data = step_wr_data;
                    wr_en0  = active_bank_reg;
                    wr_en1  = !active_bank_reg;
                end
                if (int'(cnt_reg) == WALK_ROWS + 1) begin
                    active_bank_next = !active_bank_reg;
                    state_next       = lge_pkg::ST_DONE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            lge_pkg::ST_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = lge_pkg::RES_STEP;
                    out_cell_next  = 1'b0;
                    state_next     = lge_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lge_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= lge_pkg::ST_CLEAR;
            cnt_reg         <= '0;
            active_bank_reg <= 1'b0;
            board_rows_reg  <= lge_pkg::BOARD_DIM_RESET;
            board_cols_reg  <= lge_pkg::BOARD_DIM_RESET;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            active_bank_reg <= active_bank_next;
            board_rows_reg  <= board_rows_next;
            board_cols_reg  <= board_cols_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_row_reg    <= op_row_next;
        op_col_reg    <= op_col_next;
        op_val_reg    <= op_val_next;
        op_inside_reg <= op_inside_next;
        above_reg     <= above_next;
        cur_reg       <= cur_next;
        out_kind_reg  <= out_kind_next;
        out_cell_reg  <= out_cell_next;
    end

`ifndef NO_ASSERTIONS
    a_step_result_dead: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_result_kind == lge_pkg::RES_STEP)) |-> !m_cell_out)
        else $error("step result carries a live cell");

    a_bank_flip_on_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (active_bank_reg != $past(active_bank_reg))
        |-> (!$past(aresetn) || ($past(state_reg) == lge_pkg::ST_STEP)))
        else $error("active bank changed outside a step");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> (($past(state_reg) == lge_pkg::ST_READ)
                         || ($past(state_reg) == lge_pkg::ST_DONE)))
        else $error("result raised without a read or finished step");
`endif

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for the life generation engine: cell access, generation steps, board sizes
module tb_top;

    localparam int MAX_ROWS      = 64;
    localparam int MAX_COLS      = 64;
    localparam int PHASES        = 14;
    localparam int PHASE_ITEMS   = 120;
    localparam int SETTLE_CYCLES = 80;
    localparam int STUCK_LIMIT   = 1000;

    localparam logic [lge_pkg::OP_W-1:0]      OP_UNUSED    = 2'd3;
    localparam logic [lge_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [lge_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic kind;
        logic cell_val;
    } result_t;

    typedef struct packed {
        logic [lge_pkg::OP_W-1:0]    op;
        logic [lge_pkg::COORD_W-1:0] row;
        logic [lge_pkg::COORD_W-1:0] col;
        logic                        val;
        bit                          typed;
        logic                        want_kind;
        logic                        want_cell;
    } request_row_t;

    logic                          aclk;
    logic                          aresetn       = 1'b0;
    logic                          s_valid       = 1'b0;
    logic                          s_ready;
    logic [lge_pkg::OP_W-1:0]      s_operation   = lge_pkg::OP_WRITE;
    logic [lge_pkg::COORD_W-1:0]   s_cell_row    = '0;
    logic [lge_pkg::COORD_W-1:0]   s_cell_col    = '0;
    logic                          s_cell_in     = 1'b0;
    logic                          m_valid;
    logic                          m_ready       = 1'b0;
    logic                          m_result_kind;
    logic                          m_cell_out;
    logic                          cfg_valid     = 1'b0;
    logic                          cfg_ready;
    logic [lge_pkg::CFG_IDX_W-1:0] cfg_index     = lge_pkg::CFG_BOARD_ROWS;
    logic [lge_pkg::DIM_W-1:0]     cfg_data      = '0;

    // board state as the block should hold it
    logic [MAX_COLS-1:0]       cell_bank [2][MAX_ROWS];
    logic                      live_bank  = 1'b0;
    logic [lge_pkg::DIM_W-1:0] board_rows = lge_pkg::BOARD_DIM_RESET;
    logic [lge_pkg::DIM_W-1:0] board_cols = lge_pkg::BOARD_DIM_RESET;

    result_t due_results [$];
    int      mismatches  = 0;
    int      stuck_cycles = 0;
    bit      s_idle_on   = 1'b1;
    bit      m_idle_on   = 1'b1;

    request_row_t directed_reqs [24] = '{
        '{lge_pkg::OP_READ,  6'd0,  6'd0,  1'b0, 1'b1, lge_pkg::RES_READ, 1'b0},
        '{lge_pkg::OP_READ,  6'd63, 6'd63, 1'b1, 1'b1, lge_pkg::RES_READ, 1'b0},
        '{lge_pkg::OP_WRITE, 6'd0,  6'd0,  1'b1, 1'b0, lge_pkg::RES_READ, 1'b0},
        '{lge_pkg::OP_READ,  6'd0,  6'd0,  1'b0, 1'b1, lge_pkg::RES_READ, 1'b1},
        '{lge_pkg::OP_WRITE, 6'd63, 6'd63, 1'b1, 1'b0, lge_pkg::RES_READ, 1'b0},
        '{lge_pkg::OP_READ,  6'd63, 6'd63, 1'b0, 1'b1, lge_pkg::RES_READ, 1'b1},
        '{lge_pkg::OP_WRITE, 6'd0,  6'd63, 1'b1, 1'b0, lge_pkg::RES_READ, 1'b0},
        '{lge_pkg::OP_WRITE, 6'd63, 6'd0,  1'b1, 1'b0, lge_pkg::RES_READ, 1'b0},
        '{OP_UNUSED,         6'd63, 6'd63, 1'b1, 1'b0, lge_pkg::RES_READ, 1'b0},
        '{lge_pkg::OP_STEP,  6'd0,  6'd0,  1'b0, 1'b1, lge_pkg::RES_STEP, 1'b0},
        '{lge_pkg::OP_READ,  6'd0,  6'd0,  1'b0, 1'b1, lge_pkg::RES_READ, 1'b0},
        '{lge_pkg::OP_READ,  6'd63, 6'd0,  1'b0, 1'b1, lge_pkg::RES_READ, 1'b0},
        '{lge_pkg::OP_WRITE, 6'd20, 6'd30, 1'b1, 1'b0, lge_pkg::RES_READ, 1'b0},
        '{lge_pkg::OP_WRITE, 6'd20, 6'd31, 1'b1, 1'b0, lge_pkg::RES_READ, 1'b0},
        '{lge_pkg::OP_WRITE, 6'd20, 6'd32, 1'b1, 1'b0, lge_pkg::RES_READ, 1'b0},
        '{lge_pkg::OP_STEP,  6'd42, 6'd21, 1'b1, 1'b1, lge_pkg::RES_STEP, 1'b0},
        '{lge_pkg::OP_READ,  6'd19, 6'd31, 1'b0, 1'b0, lge_pkg::RES_READ, 1'b0},
        '{lge_pkg::OP_READ,  6'd20, 6'd30, 1'b0, 1'b0, lge_pkg::RES_READ, 1'b0},
        '{lge_pkg::OP_WRITE, 6'd21, 6'd31, 1'b0, 1'b0, lge_pkg::RES_READ, 1'b0},
        '{lge_pkg::OP_READ,  6'd21, 6'd31, 1'b0, 1'b0, lge_pkg::RES_READ, 1'b0},
        '{lge_pkg::OP_WRITE, 6'd5,  6'd5,  1'b1, 1'b0, lge_pkg::RES_READ, 1'b0},
        '{lge_pkg::OP_WRITE, 6'd5,  6'd5,  1'b0, 1'b0, lge_pkg::RES_READ, 1'b0},
        '{lge_pkg::OP_READ,  6'd5,  6'd5,  1'b0, 1'b0, lge_pkg::RES_READ, 1'b0},
        '{lge_pkg::OP_READ,  6'd20, 6'd31, 1'b0, 1'b0, lge_pkg::RES_READ, 1'b0}
    };

    life_generation_engine #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_cell_row    (s_cell_row),
        .s_cell_col    (s_cell_col),
        .s_cell_in     (s_cell_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_cell_out    (m_cell_out),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int rows_in_use();
        return (board_rows > MAX_ROWS) ? MAX_ROWS : int'(board_rows);
    endfunction

    function automatic int cols_in_use();
        return (board_cols > MAX_COLS) ? MAX_COLS : int'(board_cols);
    endfunction

    function automatic void advance_board();
        int nr, nc, n, r, c, dr, dc, rr, cc;
        logic [MAX_COLS-1:0] row_bits;
        nr = rows_in_use();
        nc = cols_in_use();
        for (r = 0; r < MAX_ROWS; r++) begin
            row_bits = '0;
            for (c = 0; c < MAX_COLS; c++) begin
                if (r < nr && c < nc) begin
                    n = 0;
                    for (dr = -1; dr <= 1; dr++) begin
                        for (dc = -1; dc <= 1; dc++) begin
                            rr = r + dr;
                            cc = c + dc;
                            if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 && rr < nr && cc < nc)
                                if (cell_bank[live_bank][rr][cc])
                                    n++;
                        end
                    end
                    if (n == lge_pkg::BIRTH_COUNT
                        || (cell_bank[live_bank][r][c] && n == lge_pkg::SURVIVE_COUNT))
                        row_bits[c] = 1'b1;
                end
            end
            cell_bank[~live_bank][r] = row_bits;
        end
        live_bank = ~live_bank;
    endfunction

    function automatic void board_request(input logic [lge_pkg::OP_W-1:0] op,
                                          input logic [lge_pkg::COORD_W-1:0] row,
                                          input logic [lge_pkg::COORD_W-1:0] col,
                                          input logic val,
                                          output bit has_result,
                                          output result_t res);
        bit in_board;
        in_board   = (int'(row) < rows_in_use()) && (int'(col) < cols_in_use());
        has_result = 1'b0;
        res        = '0;
        case (op)
            lge_pkg::OP_WRITE: begin
                if (in_board)
                    cell_bank[live_bank][row][col] = val;
            end
            lge_pkg::OP_READ: begin
                has_result   = 1'b1;
                res.kind     = lge_pkg::RES_READ;
                res.cell_val = in_board ? cell_bank[live_bank][row][col] : 1'b0;
            end
            lge_pkg::OP_STEP: begin
                advance_board();
                has_result   = 1'b1;
                res.kind     = lge_pkg::RES_STEP;
                res.cell_val = 1'b0;
            end
            default: ;
        endcase
    endfunction

    function automatic logic [lge_pkg::DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 7'd1;
            2:       return 7'd64;
            3:       return 7'($urandom_range(65, 127));
            4:       return 7'($urandom_range(17, 63));
            default: return 7'($urandom_range(2, 16));
        endcase
    endfunction

    // leaves s_valid high so a back-to-back request needs no second assignment
    task automatic send_request(input logic [lge_pkg::OP_W-1:0] op,
                                input logic [lge_pkg::COORD_W-1:0] row,
                                input logic [lge_pkg::COORD_W-1:0] col,
                                input logic val,
                                input bit typed,
                                input result_t typed_res);
        int      gap;
        bit      has_result;
        result_t res;
        gap = s_idle_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_cell_row  <= row;
        s_cell_col  <= col;
        s_cell_in   <= val;
        do @(posedge aclk); while (!s_ready);
        board_request(op, row, col, val, has_result, res);
        if (has_result)
            due_results.push_back(typed ? typed_res : res);
    endtask

    task automatic write_register(input logic [lge_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [lge_pkg::DIM_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            lge_pkg::CFG_BOARD_ROWS: board_rows = val;
            lge_pkg::CFG_BOARD_COLS: board_cols = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // result side
    initial begin
        int      stall;
        result_t want;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = m_idle_on ? $urandom_range(0, 3) : 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got kind %0d cell %0d",
                         $time, m_result_kind, m_cell_out);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                if (m_result_kind !== want.kind) begin
                    $display("%0t: result_kind expected %0d got %0d",
                             $time, want.kind, m_result_kind);
                    mismatches++;
                end
                if (m_cell_out !== want.cell_val) begin
                    $display("%0t: cell_out expected %0d got %0d",
                             $time, want.cell_val, m_cell_out);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // request side and board settings
    initial begin
        int                          phase, i, pick, nr, nc;
        logic [lge_pkg::DIM_W-1:0]   rows, cols;
        logic [lge_pkg::OP_W-1:0]    op;
        logic [lge_pkg::COORD_W-1:0] row, col;
        for (i = 0; i < MAX_ROWS; i++) begin
            cell_bank[0][i] = '0;
            cell_bank[1][i] = '0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_reqs[i])
            send_request(directed_reqs[i].op, directed_reqs[i].row, directed_reqs[i].col,
                         directed_reqs[i].val, directed_reqs[i].typed,
                         '{directed_reqs[i].want_kind, directed_reqs[i].want_cell});
        drain();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       begin rows = 7'd0;   cols = 7'd7;   end
                1:       begin rows = 7'd9;   cols = 7'd0;   end
                2:       begin rows = 7'd127; cols = 7'd127; end
                3:       begin rows = 7'd1;   cols = 7'd1;   end
                4:       begin rows = 7'd1;   cols = 7'd64;  end
                5:       begin rows = 7'd64;  cols = 7'd1;   end
                6:       begin rows = 7'd3;   cols = 7'd3;   end
                default: begin rows = pick_dim(); cols = pick_dim(); end
            endcase
            write_register(lge_pkg::CFG_BOARD_ROWS, rows);
            write_register(lge_pkg::CFG_BOARD_COLS, cols);
            // spare indexes must leave the board size alone
            if (phase == 2) begin
                write_register(CFG_SPARE_LO, 7'd0);
                write_register(CFG_SPARE_HI, 7'd1);
            end
            cfg_valid <= 1'b0;
            s_idle_on = ($urandom_range(0, 3) != 0);
            m_idle_on = ($urandom_range(0, 3) != 0);
            nr = rows_in_use();
            nc = cols_in_use();

            for (i = 0; i < PHASE_ITEMS; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    op = lge_pkg::OP_WRITE;
                else if (pick < 85)
                    op = lge_pkg::OP_READ;
                else if (pick < 96)
                    op = lge_pkg::OP_STEP;
                else
                    op = OP_UNUSED;
                if ($urandom_range(0, 3) != 0 && nr > 0 && nc > 0) begin
                    row = lge_pkg::COORD_W'($urandom_range(0, nr - 1));
                    col = lge_pkg::COORD_W'($urandom_range(0, nc - 1));
                end else begin
                    row = lge_pkg::COORD_W'($urandom_range(0, 63));
                    col = lge_pkg::COORD_W'($urandom_range(0, 63));
                end
                send_request(op, row, col, 1'($urandom_range(0, 1)), 1'b0, '0);
            end
            drain();
        end

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: filelist.f
hdl/lge_pkg.sv
hdl/lge_bank_ram.sv
hdl/lge_row_rule.sv
hdl/life_generation_engine.sv
bench/tb_top.sv
